// ----- design/skc_pkg.sv -----
// shared types, operator codes and character constants for the keystroke calculator
package skc_pkg;

  // pending operator codes
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5
  } op_t;

  // control word from the sequencer to the multiply / divide unit
  typedef struct packed {
    logic start;
    logic divide;
  } unit_req_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_LOW_R = 8'h72;

  function automatic op_t op_of(input logic [7:0] ch);
    op_t op;
    case (ch)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      CH_PCT:   op = OP_MOD;
      default:  op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic logic is_ignored(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR) ||
           (ch == CH_CARET) || (ch == CH_LOW_R);
  endfunction

endpackage

// ----- design/skc_in_if.sv -----
// keystroke input channel: one character word per handshake
interface skc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_expression;

  modport source (output valid, output character, output end_of_expression, input ready);
  modport sink   (input valid, input character, input end_of_expression, output ready);
endinterface

// ----- design/skc_out_if.sv -----
// result channel: one evaluated expression word per handshake
interface skc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_value;
  logic       divide_by_zero;

  modport source (output valid, output result_value, output divide_by_zero, input ready);
  modport sink   (input valid, input result_value, input divide_by_zero, output ready);
endinterface

// ----- design/skc_muldiv.sv -----
// iterative shift-add multiplier and restoring divider around one shared adder
module skc_muldiv #(
  parameter int W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  skc_pkg::unit_req_t  req,
  input  logic [W-1:0]        a,
  input  logic [W-1:0]        b,
  output logic                done,
  output logic [W-1:0]        product,
  output logic [W-1:0]        quotient,
  output logic [W-1:0]        remainder
);

  localparam int CntW = $clog2(W + 1);
  localparam logic [CntW-1:0] Steps = CntW'(W);

  logic            busy;
  logic            divide;
  logic [CntW-1:0] count;
  logic [W-1:0]    hi;
  logic [W-1:0]    lo;

  logic [W:0]      add_x;
  logic [W:0]      add_y;
  logic [W+1:0]    add_sum;

  // multiply adds a into the high half, divide subtracts b from the shifted remainder
  always_comb begin
    if (divide) begin
      add_x = {hi, lo[W-1]};
      add_y = ~{1'b0, b};
    end else begin
      add_x = {1'b0, hi};
      add_y = lo[0] ? {1'b0, a} : '0;
    end
    add_sum = {1'b0, add_x} + {1'b0, add_y} + (W + 2)'(divide);
  end

  assign done      = busy && (count == '0);
  assign product   = (hi != '0) ? '1 : lo;
  assign quotient  = lo;
  assign remainder = hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      count <= Steps;
    end else if (done) begin
      busy  <= 1'b0;
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      divide <= req.divide;
      hi     <= '0;
      lo     <= req.divide ? a : b;
    end else if (busy && (count != '0)) begin
      if (divide) begin
        hi <= add_sum[W+1] ? add_sum[W-1:0] : add_x[W-1:0];
        lo <= {lo[W-2:0], add_sum[W+1]};
      end else begin
        hi <= add_sum[W:1];
        lo <= {add_sum[0], lo[W-1:1]};
      end
    end
  end

endmodule

// ----- design/saturating_keystroke_calculator.sv -----
// top level of the saturating keystroke calculator
// Usage: key_in carries one ASCII character word per handshake with an end flag;
// res_out carries one result word (value and divide-by-zero flag) per expression.
// Expressions evaluate strictly left to right on DATA_WIDTH-bit unsigned values.
// A digit or ignored character is taken in ST_IDLE. An operator first resolves
// the pending operator in ST_RESOLVE: add, subtract, a first operand or a
// division by zero finish there, while multiply, divide or modulo wait in
// ST_BUSY for the shared shift-add / restoring unit that runs one bit per
// cycle. The end flag runs one more resolve with the pending operator, and
// ST_EMIT then loads the result register.
// The result sits in an output register, so new characters are taken while it
// waits; a second result waits in the load step until the receiver takes the
// first one, and key_in.ready stays low meanwhile.
// Reset clears operand, accumulator, pending operator, error flag and the output
// valid flag; each result clears operand, accumulator, operator and error flag.
module saturating_keystroke_calculator #(
  parameter int DATA_WIDTH = 8
) (
  input logic       clk,
  input logic       rst,
  skc_in_if.sink    key_in,
  skc_out_if.source res_out
);

  localparam logic [DATA_WIDTH-1:0] ValMax = '1;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_RESOLVE = 4'b0010,
    ST_BUSY    = 4'b0100,
    ST_EMIT    = 4'b1000
  } state_t;

  state_t                 state, state_next;
  logic [DATA_WIDTH-1:0]  operand, operand_next;
  logic [DATA_WIDTH-1:0]  accum, accum_next;
  skc_pkg::op_t           pending, pending_next;
  skc_pkg::op_t           new_op, new_op_next;
  logic                   error_seen, error_seen_next;
  logic                   last_flag, last_flag_next;
  logic                   final_pass, final_pass_next;
  logic                   out_valid, out_valid_next;
  logic [7:0]             out_value, out_value_next;
  logic                   out_err, out_err_next;

  skc_pkg::unit_req_t     unit_req;
  logic                   unit_done;
  logic [DATA_WIDTH-1:0]  unit_product;
  logic [DATA_WIDTH-1:0]  unit_quotient;
  logic [DATA_WIDTH-1:0]  unit_remainder;

  logic                   accept;
  skc_pkg::op_t           key_op;
  logic [DATA_WIDTH+4:0]  digit_sum;
  logic [DATA_WIDTH-1:0]  digit_sat;
  logic [DATA_WIDTH:0]    add_sum;
  logic [DATA_WIDTH+7:0]  accum_ext;
  logic                   finish;
  logic [DATA_WIDTH-1:0]  finish_value;

  skc_muldiv #(.W(DATA_WIDTH)) u_muldiv (
    .clk       (clk),
    .rst       (rst),
    .req       (unit_req),
    .a         (accum),
    .b         (operand),
    .done      (unit_done),
    .product   (unit_product),
    .quotient  (unit_quotient),
    .remainder (unit_remainder)
  );

  assign key_in.ready           = (state == ST_IDLE);
  assign accept                 = key_in.valid && key_in.ready;
  assign key_op                 = skc_pkg::op_of(key_in.character);
  assign res_out.valid          = out_valid;
  assign res_out.result_value   = out_value;
  assign res_out.divide_by_zero = out_err;

  // operand * 10 + low nibble, saturating
  assign digit_sum = ({5'b0, operand} << 3) + ({5'b0, operand} << 1) +
                     {{(DATA_WIDTH + 1){1'b0}}, key_in.character[3:0]};
  assign digit_sat = (digit_sum > {5'b0, ValMax}) ? ValMax : digit_sum[DATA_WIDTH-1:0];
  assign add_sum   = {1'b0, accum} + {1'b0, operand};
  assign accum_ext = {8'b0, accum};

  always_comb begin
    state_next      = state;
    operand_next    = operand;
    accum_next      = accum;
    pending_next    = pending;
    new_op_next     = new_op;
    error_seen_next = error_seen;
    last_flag_next  = last_flag;
    final_pass_next = final_pass;
    out_valid_next  = out_valid && !res_out.ready;
    out_value_next  = out_value;
    out_err_next    = out_err;
    unit_req        = '0;
    finish          = 1'b0;
    finish_value    = accum;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (key_op != skc_pkg::OP_NONE) begin
            new_op_next     = key_op;
            last_flag_next  = key_in.end_of_expression;
            final_pass_next = 1'b0;
            state_next      = ST_RESOLVE;
          end else begin
            if (!skc_pkg::is_ignored(key_in.character)) begin
              operand_next = digit_sat;
            end
            if (key_in.end_of_expression) begin
              final_pass_next = 1'b1;
              state_next      = ST_RESOLVE;
            end
          end
        end
      end
      ST_RESOLVE: begin
        case (pending)
          skc_pkg::OP_NONE: begin
            finish       = 1'b1;
            finish_value = operand;
          end
          skc_pkg::OP_ADD: begin
            finish       = 1'b1;
            finish_value = add_sum[DATA_WIDTH] ? ValMax : add_sum[DATA_WIDTH-1:0];
          end
          skc_pkg::OP_SUB: begin
            finish       = 1'b1;
            finish_value = (operand > accum) ? '0 : accum - operand;
          end
          skc_pkg::OP_MUL: begin
            unit_req.start  = 1'b1;
            unit_req.divide = 1'b0;
            state_next      = ST_BUSY;
          end
          skc_pkg::OP_DIV, skc_pkg::OP_MOD: begin
            if (operand == '0) begin
              finish          = 1'b1;
              finish_value    = ValMax;
              error_seen_next = 1'b1;
            end else begin
              unit_req.start  = 1'b1;
              unit_req.divide = 1'b1;
              state_next      = ST_BUSY;
            end
          end
          default: begin
            finish       = 1'b1;
            finish_value = accum;
          end
        endcase
      end
      ST_BUSY: begin
        if (unit_done) begin
          finish = 1'b1;
          case (pending)
            skc_pkg::OP_MUL: finish_value = unit_product;
            skc_pkg::OP_DIV: finish_value = unit_quotient;
            skc_pkg::OP_MOD: finish_value = unit_remainder;
            default:         finish_value = accum;
          endcase
        end
      end
      ST_EMIT: begin
        // hold the result until the output register is free
        if (!out_valid || res_out.ready) begin
          out_valid_next  = 1'b1;
          out_value_next  = accum_ext[7:0];
          out_err_next    = error_seen;
          operand_next    = '0;
          accum_next      = '0;
          pending_next    = skc_pkg::OP_NONE;
          error_seen_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (finish) begin
      accum_next   = finish_value;
      operand_next = '0;
      if (final_pass) begin
        pending_next = skc_pkg::OP_NONE;
        state_next   = ST_EMIT;
      end else begin
        pending_next = new_op;
        if (last_flag) begin
          final_pass_next = 1'b1;
          state_next      = ST_RESOLVE;
        end else begin
          state_next = ST_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      operand    <= '0;
      accum      <= '0;
      pending    <= skc_pkg::OP_NONE;
      error_seen <= 1'b0;
      out_valid  <= 1'b0;
      last_flag  <= 1'b0;
      final_pass <= 1'b0;
    end else begin
      state      <= state_next;
      operand    <= operand_next;
      accum      <= accum_next;
      pending    <= pending_next;
      error_seen <= error_seen_next;
      out_valid  <= out_valid_next;
      last_flag  <= last_flag_next;
      final_pass <= final_pass_next;
    end
  end

  always_ff @(posedge clk) begin
    new_op    <= new_op_next;
    out_value <= out_value_next;
    out_err   <= out_err_next;
  end

endmodule

// ----- design/skc_checker.sv -----
// port-level assertions for the keystroke calculator, bound to the top level
module skc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_character,
  input logic       in_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_value,
  input logic       out_err
);

  logic in_accept;
  logic in_is_op;

  assign in_accept = in_valid && in_ready;
  assign in_is_op  = (in_character == skc_pkg::CH_PLUS) || (in_character == skc_pkg::CH_MINUS) ||
                     (in_character == skc_pkg::CH_STAR) || (in_character == skc_pkg::CH_SLASH) ||
                     (in_character == skc_pkg::CH_PCT);

  // an operator always goes through a resolve
  a_op_stalls: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_is_op |=> !in_ready)
    else $error("operator word did not stall the input");

  // the last word always goes through a resolve
  a_end_stalls: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_end |=> !in_ready)
    else $error("end word did not stall the input");

  // a plain digit in the middle of an expression makes no result
  a_digit_quiet: assert property (@(posedge clk) disable iff (rst)
    in_accept && !in_end && !in_is_op |=> !$rose(out_valid))
    else $error("result appeared after a mid-expression digit");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_err))
    else $error("stalled result word changed");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind saturating_keystroke_calculator skc_checker u_skc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (key_in.valid),
  .in_ready     (key_in.ready),
  .in_character (key_in.character),
  .in_end       (key_in.end_of_expression),
  .out_valid    (res_out.valid),
  .out_ready    (res_out.ready),
  .out_value    (res_out.result_value),
  .out_err      (res_out.divide_by_zero)
);

// ----- tb/sv/tb_saturating_keystroke_calculator.sv -----
// testbench for the saturating keystroke calculator: directed and random expressions vs a predictor
`timescale 1ns / 1ps

module tb_saturating_keystroke_calculator;

  localparam int KEY_TARGET = 1250;
  localparam int QUIET_FROM = 1100;
  // the limit sits far above the slowest run, idle gaps and result stalls included
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [7:0] VAL_MAX = 8'hFF;

  typedef struct packed {
    logic [7:0] value;
    logic       dbz;
  } calc_result_t;

  logic clk;
  logic rst;

  skc_in_if  key_in ();
  skc_out_if res_out ();

  saturating_keystroke_calculator u_top (
    .clk     (clk),
    .rst     (rst),
    .key_in  (key_in),
    .res_out (res_out)
  );

  // predictor state
  logic [7:0]   operand_reg = 8'd0;
  logic [7:0]   accum_reg = 8'd0;
  skc_pkg::op_t pending_op = skc_pkg::OP_NONE;
  logic         error_flag = 1'b0;

  calc_result_t answer_q[$];
  calc_result_t head;

  logic [7:0] skip_keys [6] = '{skc_pkg::CH_SPACE, skc_pkg::CH_TAB, skc_pkg::CH_LF,
                                skc_pkg::CH_CR, skc_pkg::CH_CARET, skc_pkg::CH_LOW_R};
  logic [7:0] op_keys [5] = '{skc_pkg::CH_PLUS, skc_pkg::CH_MINUS, skc_pkg::CH_STAR,
                              skc_pkg::CH_SLASH, skc_pkg::CH_PCT};

  int keys_counted = 0;
  int keys_skipped = 0;
  int results_checked = 0;
  int dbz_results = 0;
  int fault_count = 0;
  int cycle_count = 0;
  int ready_hold = 0;
  int send_idle_pct = 20;
  int stall_pct = 20;
  bit quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               answer_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // apply the pending operator to the accumulator, then clear operand and operator
  task automatic fold_pending();
    logic [15:0] wide;
    wide = 16'd0;
    case (pending_op)
      skc_pkg::OP_NONE: accum_reg = operand_reg;
      skc_pkg::OP_ADD: begin
        wide = {8'd0, accum_reg} + {8'd0, operand_reg};
        accum_reg = (wide > 16'd255) ? VAL_MAX : wide[7:0];
      end
      skc_pkg::OP_SUB: accum_reg = (operand_reg > accum_reg) ? 8'd0 : accum_reg - operand_reg;
      skc_pkg::OP_MUL: begin
        wide = {8'd0, accum_reg} * {8'd0, operand_reg};
        accum_reg = (wide > 16'd255) ? VAL_MAX : wide[7:0];
      end
      skc_pkg::OP_DIV, skc_pkg::OP_MOD: begin
        if (operand_reg == 8'd0) begin
          accum_reg = VAL_MAX;
          error_flag = 1'b1;
        end else if (pending_op == skc_pkg::OP_DIV) begin
          accum_reg = accum_reg / operand_reg;
        end else begin
          accum_reg = accum_reg % operand_reg;
        end
      end
      default: ;
    endcase
    operand_reg = 8'd0;
    pending_op = skc_pkg::OP_NONE;
  endtask

  task automatic step_calculator(input logic [7:0] ch, input logic last);
    skc_pkg::op_t op;
    logic [15:0]  wide;
    calc_result_t answer;
    case (ch)
      skc_pkg::CH_PLUS:  op = skc_pkg::OP_ADD;
      skc_pkg::CH_MINUS: op = skc_pkg::OP_SUB;
      skc_pkg::CH_STAR:  op = skc_pkg::OP_MUL;
      skc_pkg::CH_SLASH: op = skc_pkg::OP_DIV;
      skc_pkg::CH_PCT:   op = skc_pkg::OP_MOD;
      default:           op = skc_pkg::OP_NONE;
    endcase
    if (op != skc_pkg::OP_NONE) begin
      fold_pending();
      pending_op = op;
      keys_counted++;
    end else if (ch == skc_pkg::CH_SPACE || ch == skc_pkg::CH_TAB || ch == skc_pkg::CH_LF ||
                 ch == skc_pkg::CH_CR || ch == skc_pkg::CH_CARET ||
                 ch == skc_pkg::CH_LOW_R) begin
      if (last) keys_counted++;
      else keys_skipped++;
    end else begin
      // anything else is a digit worth its low nibble
      wide = {8'd0, operand_reg} * 16'd10 + {12'd0, ch[3:0]};
      operand_reg = (wide > 16'd255) ? VAL_MAX : wide[7:0];
      keys_counted++;
    end
    if (last) begin
      fold_pending();
      answer.value = accum_reg;
      answer.dbz = error_flag;
      answer_q.push_back(answer);
      accum_reg = 8'd0;
      error_flag = 1'b0;
    end
  endtask

  task automatic send_key(input logic [7:0] ch, input logic last);
    if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
      key_in.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    key_in.valid <= 1'b1;
    key_in.character <= ch;
    key_in.end_of_expression <= last;
    @(posedge clk);
    while (!key_in.ready) @(posedge clk);
    step_calculator(ch, last);
  endtask

  task automatic send_string(input string keys);
    for (int i = 0; i < keys.len(); i++) send_key(keys[i], i == keys.len() - 1);
  endtask

  task automatic send_expression();
    logic [7:0] seq[$];
    int         terms;
    int         digits;
    int         n;
    if ($urandom_range(0, 99) < 15) begin
      // raw bytes; the end flag may be missing so state runs into the next expression
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++)
        send_key(8'($urandom_range(0, 255)),
                 (i == n - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 24) == 0));
    end else begin
      terms = $urandom_range(1, 5);
      for (int t = 0; t < terms; t++) begin
        if (t > 0) seq.push_back(op_keys[$urandom_range(0, 4)]);
        digits = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
        for (int d = 0; d < digits; d++) begin
          if ($urandom_range(0, 9) == 0) seq.push_back(skip_keys[$urandom_range(0, 5)]);
          // zero digits often, so divide and modulo by zero come up
          seq.push_back(8'(8'h30 + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9))));
        end
      end
      if ($urandom_range(0, 9) == 0 || seq.size() == 0) seq.push_back(op_keys[$urandom_range(0, 4)]);
      for (int i = 0; i < seq.size(); i++) send_key(seq[i], i == seq.size() - 1);
    end
  endtask

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // result side: random stall bursts, none once quiet
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      res_out.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      ready_hold <= $urandom_range(0, 16);
      res_out.ready <= 1'b0;
    end else begin
      res_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_out.valid && res_out.ready) begin
      if (answer_q.size() == 0) begin
        note_fault($sformatf("unexpected word: value %0d flag %0b", res_out.result_value,
                             res_out.divide_by_zero));
      end else begin
        head = answer_q.pop_front();
        results_checked++;
        if (head.dbz) dbz_results++;
        if (res_out.result_value !== head.value)
          note_fault($sformatf("result_value expected %0d got %0d", head.value,
                               res_out.result_value));
        if (res_out.divide_by_zero !== head.dbz)
          note_fault($sformatf("divide_by_zero expected %0b got %0b", head.dbz,
                               res_out.divide_by_zero));
      end
    end
  end

  // field extremes, high-bit byte, nibble above nine, operand saturation
  task automatic test_edge_keys();
    send_key(8'h00, 1'b0);
    send_key(8'hFF, 1'b1);
    send_string("999");
  endtask

  task automatic test_add_subtract();
    send_string("5-9");
    send_string("250+9");
  endtask

  task automatic test_multiply_divide();
    send_string("99*9");
    send_string("7/0");
  endtask

  // every ignored character but space, ending on carriage return, after a modulo by zero
  task automatic test_ignored_keys();
    send_string("6%^r\t\n\015");
  endtask

  task automatic test_random_expressions();
    while (keys_counted < QUIET_FROM) begin
      if ($urandom_range(0, 7) == 0) begin
        send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      send_expression();
    end
  endtask

  task automatic test_steady_stream();
    quiet = 1'b1;
    while (keys_counted < KEY_TARGET) send_expression();
  endtask

  initial begin
    rst = 1'b1;
    key_in.valid = 1'b0;
    key_in.character = 8'd0;
    key_in.end_of_expression = 1'b0;
    res_out.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_edge_keys();
    test_add_subtract();
    test_multiply_divide();
    test_ignored_keys();
    test_random_expressions();
    test_steady_stream();

    key_in.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d keystrokes plus %0d ignored ones", keys_counted, keys_skipped);
    $display("checked %0d expression results, %0d flagged divide by zero, %0d faults",
             results_checked, dbz_results, fault_count);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/skc_pkg.sv
design/skc_in_if.sv
design/skc_out_if.sv
design/skc_muldiv.sv
design/saturating_keystroke_calculator.sv
design/skc_checker.sv
tb/sv/tb_saturating_keystroke_calculator.sv
